>>> design/stai_pkg.sv
// Package: shared types and constants for the sample time anchor interpolator.
package stai_pkg;

	localparam logic [39:0] PS_PER_SEC = 40'd1000000000000;
	localparam logic [19:0] MICRO      = 20'd1000000;
	localparam logic [9:0]  MILLI      = 10'd1000;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_GET   = 2'd1,
		OP_STAMP = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_SAMPLE_RATE = 2'd0,
		REG_COARSE_AGE  = 2'd1,
		REG_INVALID_AGE = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GET_RD,
		ST_GET_DATA,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_PREP,
		ST_DIV_Q,
		ST_MUL2,
		ST_DIV_F,
		ST_FIX,
		ST_DIV_A,
		ST_FINAL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [52:0] samp_idx;
		logic [39:0] anchor_seconds;
		logic [39:0] anchor_picoseconds;
		logic [3:0]  anchor_source;
		logic [7:0]  anchor_flags;
		logic [3:0]  anchor_accuracy;
		logic [31:0] drop_cnt;
		logic        drop_unsized;
		logic        drop_overrun;
	} req_t;

	typedef struct packed {
		logic        status;
		logic        time_ok;
		logic [39:0] out_seconds;
		logic [39:0] out_picoseconds;
		logic [3:0]  out_source;
		logic [7:0]  out_flags;
		logic [3:0]  out_accuracy;
		logic        discontinuity;
		logic        discontinuity_overrun;
		logic [52:0] out_anchor_index;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] value;
	} cfg_t;

	typedef struct packed {
		logic [52:0] idx;
		logic [39:0] sec;
		logic [39:0] ps;
		logic [3:0]  src;
		logic [7:0]  flags;
		logic [3:0]  acc;
	} entry_t;

endpackage

>>> design/stai_chan_if.sv
// Interface: valid/ready channel carrying one payload of type T.
interface stai_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> design/sample_time_anchor_interpolator_top.sv
// Top level: anchor ring in one memory, search sequencer and shared serial divider.

// Anchors live in one synchronous memory of ANCHOR_DEPTH entries with a registered
// read; ring head and fill count are flops, so there is no clearing pass after reset.
// One item is handled at a time; req.ready is high while the sequencer is idle, and
// a finished result sits in the rsp register while the next item is taken. A stamp
// reads one slot at a time in the newest-to-oldest search (one memory read port),
// then, with a nonzero rate, uses one shared restoring divider that gives one quotient
// bit a cycle for delta/rate (53 bits), the picosecond fraction (72 bits) and the age in
// milliseconds (63 bits). With a zero rate the divider is skipped and ST_PREP goes
// straight to ST_FINAL.
// Configuration writes are taken at any time and must only occur while idle.
module sample_time_anchor_interpolator_top
	import stai_pkg::*;
#(
	parameter int ANCHOR_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	stai_chan_if.sink   req,
	stai_chan_if.source rsp,
	stai_chan_if.sink   cfg
);

	localparam int AW = (ANCHOR_DEPTH > 1) ? $clog2(ANCHOR_DEPTH) : 1;
	localparam int CW = $clog2(ANCHOR_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(ANCHOR_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(ANCHOR_DEPTH);

	// configuration
	logic [31:0] rate_q, coarse_q, invalid_q;

	// control
	state_t        st_q, st_d;
	logic [AW-1:0] head_q, rd_ptr_q;
	logic [CW-1:0] count_q, left_q;
	logic          rsp_valid_q;
	logic [6:0]    div_cnt_q;

	// payload
	req_t        item_q;
	rsp_t        res_q, rsp_q;
	entry_t      mem [ANCHOR_DEPTH];
	entry_t      mem_rd_s1;
	entry_t      ent_q;
	logic [39:0] sec_q;
	logic [40:0] ps_q;
	logic [52:0] delta_q;
	logic [62:0] age_q;
	logic [51:0] m1_q;
	logic [71:0] num_q;
	logic [31:0] rem_q;

	logic          acc_req, rsp_free, hit;
	logic [AW-1:0] head_prev;
	logic [32:0]   trial;
	logic          qbit;

	assign acc_req   = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign head_prev = (head_q == '0) ? LAST_SLOT : head_q - AW'(1);
	assign hit       = (mem_rd_s1.idx <= item_q.samp_idx);

	// one restoring-division step
	assign trial = {rem_q, num_q[71]};
	assign qbit  = (trial >= {1'b0, rate_q});

	assign req.ready = (st_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= '0;
			coarse_q  <= '0;
			invalid_q <= '0;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.data.index))
				REG_SAMPLE_RATE: rate_q    <= cfg.data.value;
				REG_COARSE_AGE:  coarse_q  <= cfg.data.value;
				REG_INVALID_AGE: invalid_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (req.valid) begin
					unique case (op_t'(req.data.opcode))
						OP_GET:   st_d = (count_q == '0) ? ST_OUT : ST_GET_RD;
						OP_STAMP: st_d = (count_q == '0) ? ST_OUT : ST_SRCH_RD;
						default:  st_d = ST_OUT;
					endcase
				end
			end
			ST_GET_RD:   st_d = ST_GET_DATA;
			ST_GET_DATA: st_d = ST_OUT;
			ST_SRCH_RD:  st_d = ST_SRCH_CMP;
			ST_SRCH_CMP: begin
				priority if (hit) st_d = ST_PREP;
				else if (left_q == CW'(1)) st_d = ST_OUT;
				else st_d = ST_SRCH_RD;
			end
			ST_PREP:  st_d = (rate_q == '0) ? ST_FINAL : ST_DIV_Q;
			ST_DIV_Q: if (div_cnt_q == '0) st_d = ST_MUL2;
			ST_MUL2:  st_d = ST_DIV_F;
			ST_DIV_F: if (div_cnt_q == '0) st_d = ST_FIX;
			ST_FIX:   st_d = ST_DIV_A;
			ST_DIV_A: if (div_cnt_q == '0) st_d = ST_FINAL;
			ST_FINAL: st_d = ST_OUT;
			ST_OUT:   if (rsp_free) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// ring pointers, search counter, divider count, result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			left_q      <= '0;
			div_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc_req) begin
				rd_ptr_q <= head_prev;
				left_q   <= count_q;
				if (op_t'(req.data.opcode) == OP_PUSH) begin
					head_q <= (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
					if (count_q != FULL_CNT) count_q <= count_q + CW'(1);
				end
			end
			if (st_q == ST_SRCH_CMP && !hit) begin
				left_q   <= left_q - CW'(1);
				rd_ptr_q <= (rd_ptr_q == '0) ? LAST_SLOT : rd_ptr_q - AW'(1);
			end
			unique case (st_q)
				ST_PREP: div_cnt_q <= 7'd53;
				ST_MUL2: div_cnt_q <= 7'd72;
				ST_FIX:  div_cnt_q <= 7'd63;
				ST_DIV_Q, ST_DIV_F, ST_DIV_A:
					if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - 7'd1;
				default: ;
			endcase
			if (st_q == ST_OUT && rsp_free) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// anchor memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (acc_req && op_t'(req.data.opcode) == OP_PUSH) begin
			mem[head_q] <= '{idx: req.data.samp_idx, sec: req.data.anchor_seconds,
				ps: req.data.anchor_picoseconds, src: req.data.anchor_source,
				flags: req.data.anchor_flags, acc: req.data.anchor_accuracy};
		end
		mem_rd_s1 <= mem[rd_ptr_q];
	end

	// datapath
	always_ff @(posedge clk) begin
		if (acc_req) begin
			item_q <= req.data;
			res_q  <= '0;
			if (op_t'(req.data.opcode) == OP_GET && count_q == '0) res_q.status <= 1'b1;
			if (op_t'(req.data.opcode) == OP_STAMP &&
			    (req.data.drop_cnt != '0 || req.data.drop_unsized)) begin
				res_q.discontinuity         <= 1'b1;
				res_q.discontinuity_overrun <= req.data.drop_overrun;
			end
		end
		if (st_q == ST_OUT && rsp_free) rsp_q <= res_q;
		unique case (st_q)
			ST_GET_DATA: begin
				res_q.out_seconds      <= mem_rd_s1.sec;
				res_q.out_picoseconds  <= mem_rd_s1.ps;
				res_q.out_source       <= mem_rd_s1.src;
				res_q.out_flags        <= mem_rd_s1.flags;
				res_q.out_accuracy     <= mem_rd_s1.acc;
				res_q.out_anchor_index <= mem_rd_s1.idx;
			end
			ST_SRCH_CMP: ent_q <= mem_rd_s1;
			ST_PREP: begin
				// fold an out-of-range picosecond count into the seconds
				if (ent_q.ps >= PS_PER_SEC) begin
					ps_q  <= {1'b0, ent_q.ps - PS_PER_SEC};
					sec_q <= ent_q.sec + 40'd1;
				end else begin
					ps_q  <= {1'b0, ent_q.ps};
					sec_q <= ent_q.sec;
				end
				delta_q <= item_q.samp_idx - ent_q.idx;
				num_q   <= {item_q.samp_idx - ent_q.idx, 19'd0};
				rem_q   <= '0;
				age_q   <= '0;
			end
			ST_DIV_Q, ST_DIV_F, ST_DIV_A: begin
				if (div_cnt_q != '0) begin
					rem_q <= qbit ? 32'(trial - {1'b0, rate_q}) : trial[31:0];
					num_q <= {num_q[70:0], qbit};
				end else if (st_q == ST_DIV_Q) begin
					sec_q <= sec_q + num_q[39:0];
					m1_q  <= rem_q * MICRO;
				end else if (st_q == ST_DIV_F) begin
					ps_q <= ps_q + {1'b0, num_q[39:0]};
				end else begin
					age_q <= num_q[62:0];
				end
			end
			ST_MUL2: begin
				num_q <= m1_q * MICRO;
				rem_q <= '0;
			end
			ST_FIX: begin
				if (ps_q >= {1'b0, PS_PER_SEC}) begin
					ps_q  <= ps_q - {1'b0, PS_PER_SEC};
					sec_q <= sec_q + 40'd1;
				end
				// full 63-bit product: delta can be up to 2^53 - 1
				num_q <= {63'(delta_q) * 63'(MILLI), 9'd0};
				rem_q <= '0;
			end
			ST_FINAL: begin
				if (!(invalid_q != '0 && age_q > {31'd0, invalid_q})) begin
					res_q.time_ok         <= 1'b1;
					res_q.out_seconds     <= sec_q;
					res_q.out_picoseconds <= ps_q[39:0];
					res_q.out_source      <= ent_q.src;
					res_q.out_flags       <= ent_q.flags;
					res_q.out_accuracy    <= (coarse_q != '0 && age_q > {31'd0, coarse_q}
						&& ent_q.acc != '0) ? 4'd1 : ent_q.acc;
				end
			end
			default: ;
		endcase
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("ring count beyond depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_SLOT) else $error("ring head beyond last slot");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status |-> !rsp_q.time_ok && rsp_q.out_seconds == '0
		&& rsp_q.out_anchor_index == '0 && !rsp_q.discontinuity)
		else $error("no-anchor response carries data");

	a_ps_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.time_ok |-> rsp_q.out_picoseconds < PS_PER_SEC)
		else $error("stamped picoseconds out of range");

	a_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.discontinuity_overrun |-> rsp_q.discontinuity)
		else $error("overrun reported without discontinuity");

endmodule
